>>> hw/rtl/pht_pkg.sv
// Shared types and constants for the periodic hit timer.
// Holds the controller/datapath command and status structs and the state enum.
// No dependencies.
`timescale 1ns / 1ps

package pht_pkg;

    localparam int unsigned TIME_W     = 32;
    localparam int unsigned PERIOD_W   = 31;
    // one restoring step per bit of the difference below its sign bit
    localparam int unsigned DIV_STEPS  = PERIOD_W;
    localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_FINISH
    } t_state;

    // how the event mark moves when the result is committed
    typedef enum logic [1:0] {
        ADV_NONE,
        ADV_ONE,
        ADV_DIV
    } t_adv;

    typedef struct packed {
        logic cap;       // capture reading and difference
        logic check;     // classify difference, set up division
        logic div_step;  // one restoring division step
        logic commit;    // update mark and load the output register
        t_adv adv;       // mark update kind used on commit
    } t_dp_cmd;

    typedef struct packed {
        logic period_zero;
        logic below;     // difference negative or under one period
        logic single;    // difference under two periods
        logic div_last;  // final division step in progress
        logic out_free;  // output register can take a result this cycle
    } t_dp_status;

endpackage

>>> hw/rtl/pht_ctrl.sv
// Sequencer for the periodic hit timer.
// Walks each transfer through check, optional division and finish; uses pht_pkg.
`timescale 1ns / 1ps

module pht_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  pht_pkg::t_dp_status i_status,
    output pht_pkg::t_dp_cmd    o_cmd
);
    import pht_pkg::*;

    t_state r_state, n_state;
    t_adv   r_mode, n_mode;

    // state and mode registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_mode  <= ADV_NONE;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_mode  = r_mode;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (i_status.period_zero || i_status.below) begin
                    n_mode  = ADV_NONE;
                    n_state = ST_FINISH;
                end else if (i_status.single) begin
                    n_mode  = ADV_ONE;
                    n_state = ST_FINISH;
                end else begin
                    n_mode  = ADV_DIV;
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (i_status.div_last) n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (i_status.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd          = '0;
        o_cmd.adv      = r_mode;
        o_in_stall     = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.cap  = i_in_valid;
            end
            ST_CHECK:  o_cmd.check    = 1'b1;
            ST_DIV:    o_cmd.div_step = 1'b1;
            ST_FINISH: o_cmd.commit   = i_status.out_free;
            default:   o_in_stall     = 1'b1;
        endcase
    end

    // division runs until its final step
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && !i_status.div_last) |=> (r_state == ST_DIV))
        else $error("division left early");

    // finish returns to idle once the result is loaded
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINISH && i_status.out_free) |=> (r_state == ST_IDLE))
        else $error("finish did not retire");

    // a miss or a zero period leaves the mark in place
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CHECK && (i_status.below || i_status.period_zero))
        |=> (r_mode == ADV_NONE))
        else $error("mark would move on a miss or zero period");

endmodule

>>> hw/rtl/pht_dp.sv
// Datapath for the periodic hit timer: period, event mark, difference,
// restoring remainder unit and output register. Uses pht_pkg.
`timescale 1ns / 1ps

module pht_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [pht_pkg::PERIOD_W-1:0]        i_cfg_period,
    input  logic [pht_pkg::TIME_W-1:0]          i_now_ms,
    input  logic                                i_out_stall,
    output logic                                o_out_valid,
    output logic                                o_hit,
    input  pht_pkg::t_dp_cmd                    i_cmd,
    output pht_pkg::t_dp_status                 o_status
);
    import pht_pkg::*;

    logic [PERIOD_W-1:0]  r_period;
    logic [TIME_W-1:0]    r_mark;
    logic [TIME_W-1:0]    r_now;
    logic [TIME_W-1:0]    r_d;
    logic [PERIOD_W-1:0]  r_dsh;
    logic [PERIOD_W-1:0]  r_rem;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_hit;
    logic                 r_out_valid;
    logic                 r_out_hit;

    logic [TIME_W-1:0]    w_cat;
    logic [TIME_W:0]      w_trial;
    logic [TIME_W-1:0]    w_period_ext;

    assign w_period_ext = {1'b0, r_period};

    // status for the controller
    always_comb begin
        o_status.period_zero = (r_period == '0);
        o_status.below       = r_d[TIME_W-1] || (r_d < w_period_ext);
        o_status.single      = (r_d < {r_period, 1'b0});
        o_status.div_last    = (r_cnt == DIV_CNT_W'(DIV_STEPS - 1));
        o_status.out_free    = !r_out_valid || !i_out_stall;
    end

    // period register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= '0;
        end else if (i_cfg_we) begin
            r_period <= i_cfg_period;
        end
    end

    // restoring step: shift in next bit, subtract period if it fits
    assign w_cat   = {r_rem, r_dsh[PERIOD_W-1]};
    assign w_trial = {1'b0, w_cat} - {1'b0, w_period_ext};

    // capture, classify and divide
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_now <= i_now_ms;
            r_d   <= i_now_ms - r_mark;
        end
        if (i_cmd.check) begin
            r_hit <= o_status.period_zero || !o_status.below;
            r_dsh <= r_d[PERIOD_W-1:0];
            r_rem <= '0;
            r_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_dsh <= {r_dsh[PERIOD_W-2:0], 1'b0};
            r_cnt <= r_cnt + 1'b1;
            if (!w_trial[TIME_W]) begin
                r_rem <= w_trial[PERIOD_W-1:0];
            end else begin
                r_rem <= w_cat[PERIOD_W-1:0];
            end
        end
    end

    // advance the event mark on commit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mark <= '0;
        end else if (i_cmd.commit) begin
            case (i_cmd.adv)
                ADV_ONE: r_mark <= r_mark + w_period_ext;
                // mark + d - d mod p equals now - d mod p
                ADV_DIV: r_mark <= r_now - {1'b0, r_rem};
                default: r_mark <= r_mark;
            endcase
        end
    end

    // output register: load on commit, drop on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_hit <= r_hit;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_hit       = r_out_hit;

    // remainder is below the period when a divided result is committed
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && i_cmd.adv == ADV_DIV) |-> (r_rem < r_period))
        else $error("remainder not below period");

    // zero period never moves the mark
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && r_period == '0) |=> $stable(r_mark))
        else $error("mark moved with zero period");

    // commit never overwrites a result still waiting
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> (!r_out_valid || !i_out_stall))
        else $error("output result overwritten");

endmodule

>>> hw/rtl/periodic_hit_timer_with_catchup.sv
// Periodic hit timer with catch-up, top level.
// Each input transfer is captured and classified, runs through the 31-step
// remainder unit only when the mark skips missed periods, and is then committed.
// A new input is taken only after the previous result has been committed.
// Synchronous active-low reset clears period, event mark and control state.
// Instantiates pht_ctrl and pht_dp; uses pht_pkg.
`timescale 1ns / 1ps

module periodic_hit_timer_with_catchup (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [pht_pkg::TIME_W-1:0]    i_now_ms,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_hit,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [pht_pkg::PERIOD_W-1:0]  i_cfg_period
);
    import pht_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // configuration is always taken
    assign o_cfg_ready = 1'b1;

    pht_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    pht_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_valid && o_cfg_ready),
        .i_cfg_period (i_cfg_period),
        .i_now_ms     (i_now_ms),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_hit        (o_hit),
        .i_cmd        (w_cmd),
        .o_status     (w_status)
    );

endmodule
